/* src/qvr_pkg.sv */
// Shared widths and constants for the quaternion vector rotator.
`default_nettype none
package qvr_pkg;

   localparam int QW    = 16;            // quaternion component, Q2.14
   localparam int VW    = 32;            // vector component, Q16.16
   localparam int LANES = 3;             // x, y, z
   localparam int SQW   = 2 * QW;        // square of a component
   localparam int PW    = QW + VW;       // component times vector element
   localparam int DENW  = SQW + 1;       // |q|^2, unsigned, up to 2^32
   localparam int AW    = SQW + 2;       // w^2 - u.u, signed
   localparam int DW    = PW + 2;        // u.v, signed
   localparam int CW    = PW + 1;        // cross product term, signed
   localparam int NW    = 72;            // numerator, signed
   localparam int QBITS = VW;            // quotient bits resolved one per stage
   localparam int REMW  = DENW;          // partial remainder, below den

   localparam logic [VW-1:0] POS_MAX = {1'b0, {(VW-1){1'b1}}};
   localparam logic [VW-1:0] NEG_MIN = {1'b1, {(VW-1){1'b0}}};

   typedef struct packed {
      logic saturated;
      logic degenerate;
   } rsp_flags_type;

endpackage
`default_nettype wire

/* src/quaternion_vector_rotate.sv */
// Pipelined quaternion vector rotator, q * (0, v) * q^-1 in fixed point.
//
//  channel  dir  handshake             payload (lowest bit first)
//  req      in   req_tvalid/tready     q_w, q_i, q_j, q_k (16 b), vec_x, vec_y, vec_z (32 b)
//  rsp      out  rsp_tvalid/tready     rot_x, rot_y, rot_z (32 b); tuser: degenerate, saturated
//
//  One request enters per clock while no stall holds req_tready low. The path is 38 register
//  stages: five of products, sums and the overflow check, 32 divider stages that each
//  resolve one quotient bit, then the output register. Reset clears the stage valid bits
//  and the output/skid valid bits; payload is not reset. A stall freezes every stage
//  together; the skid register behind the output register keeps req_tready a registered
//  signal.
`default_nettype none
module quaternion_vector_rotate (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [159:0] req_tdata,  // q_w, q_i, q_j, q_k, vec_x, vec_y, vec_z
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [95:0]       rsp_tdata,  // rot_x, rot_y, rot_z
   output qvr_pkg::rsp_flags_type rsp_tuser  // degenerate, saturated
);
   import qvr_pkg::*;

   logic skid_v_ff;
   logic en;
   assign en = ~skid_v_ff;

   // ---- unpack ----
   logic signed [QW-1:0] in_w;
   logic signed [QW-1:0] in_u [LANES];
   logic signed [VW-1:0] in_v [LANES];
   always_comb begin
      in_w = $signed(req_tdata[15:0]);
      for (int k = 0; k < LANES; k++) begin
         in_u[k] = $signed(req_tdata[QW*(k+1) +: QW]);
         in_v[k] = $signed(req_tdata[4*QW + VW*k +: VW]);
      end
   end

   // ---- stage 1: all first-level products ----
   logic                  s1_v_ff;
   logic signed [SQW-1:0] s1_ww_ff;
   logic signed [SQW-1:0] s1_sq_ff [LANES];
   logic signed [PW-1:0]  s1_dp_ff [LANES];
   logic signed [PW-1:0]  s1_cp_ff [2*LANES];
   logic signed [QW-1:0]  s1_w_ff;
   logic signed [QW-1:0]  s1_u_ff [LANES];
   logic signed [VW-1:0]  s1_vv_ff [LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_tvalid;
      end
      if (en) begin
         s1_ww_ff <= in_w * in_w;
         for (int k = 0; k < LANES; k++) begin
            s1_sq_ff[k] <= in_u[k] * in_u[k];
            s1_dp_ff[k] <= in_u[k] * in_v[k];
            s1_u_ff[k]  <= in_u[k];
            s1_vv_ff[k] <= in_v[k];
         end
         // cross product halves: (j*vz, k*vy), (k*vx, i*vz), (i*vy, j*vx)
         s1_cp_ff[0] <= in_u[1] * in_v[2];
         s1_cp_ff[1] <= in_u[2] * in_v[1];
         s1_cp_ff[2] <= in_u[2] * in_v[0];
         s1_cp_ff[3] <= in_u[0] * in_v[2];
         s1_cp_ff[4] <= in_u[0] * in_v[1];
         s1_cp_ff[5] <= in_u[1] * in_v[0];
         s1_w_ff <= in_w;
      end
   end

   // ---- stage 2: |q|^2, w^2 - u.u, u.v, u x v ----
   logic                   s2_v_ff;
   logic                   s2_degen_ff;
   logic [DENW-1:0]        s2_den_ff;
   logic [DENW-1:0]        s2_den_in;
   logic signed [AW-1:0]   s2_a_ff;
   logic signed [DW-1:0]   s2_d_ff;
   logic signed [CW-1:0]   s2_c_ff [LANES];
   logic signed [QW-1:0]   s2_w_ff;
   logic signed [QW-1:0]   s2_u_ff [LANES];
   logic signed [VW-1:0]   s2_vv_ff [LANES];

   assign s2_den_in = DENW'($unsigned(s1_ww_ff)) + DENW'($unsigned(s1_sq_ff[0]))
                    + DENW'($unsigned(s1_sq_ff[1])) + DENW'($unsigned(s1_sq_ff[2]));

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (en) begin
         s2_v_ff <= s1_v_ff;
      end
      if (en) begin
         s2_den_ff   <= s2_den_in;
         s2_degen_ff <= (s2_den_in == '0);
         s2_a_ff <= AW'(s1_ww_ff) - AW'(s1_sq_ff[0]) - AW'(s1_sq_ff[1]) - AW'(s1_sq_ff[2]);
         s2_d_ff <= DW'(s1_dp_ff[0]) + DW'(s1_dp_ff[1]) + DW'(s1_dp_ff[2]);
         for (int k = 0; k < LANES; k++) begin
            s2_c_ff[k]  <= CW'(s1_cp_ff[2*k]) - CW'(s1_cp_ff[2*k+1]);
            s2_u_ff[k]  <= s1_u_ff[k];
            s2_vv_ff[k] <= s1_vv_ff[k];
         end
         s2_w_ff <= s1_w_ff;
      end
   end

   // ---- stage 3: numerator terms ----
   logic                      s3_v_ff;
   logic                      s3_degen_ff;
   logic [DENW-1:0]           s3_den_ff;
   logic signed [AW+VW-1:0]   s3_pa_ff [LANES];
   logic signed [DW+QW:0]     s3_pd_ff [LANES];
   logic signed [CW+QW:0]     s3_pc_ff [LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (en) begin
         s3_v_ff <= s2_v_ff;
      end
      if (en) begin
         for (int k = 0; k < LANES; k++) begin
            s3_pa_ff[k] <= s2_a_ff * s2_vv_ff[k];
            s3_pd_ff[k] <= s2_d_ff * $signed({s2_u_ff[k], 1'b0});
            s3_pc_ff[k] <= $signed({s2_w_ff, 1'b0}) * s2_c_ff[k];
         end
         s3_den_ff   <= s2_den_ff;
         s3_degen_ff <= s2_degen_ff;
      end
   end

   // ---- stage 4: sum, sign and magnitude ----
   logic                s4_v_ff;
   logic                s4_degen_ff;
   logic [DENW-1:0]     s4_den_ff;
   logic [NW-1:0]       s4_mag_ff [LANES];
   logic [LANES-1:0]    s4_neg_ff;
   logic signed [NW-1:0] s4_n [LANES];

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         s4_n[k] = NW'(s3_pa_ff[k]) + NW'(s3_pd_ff[k]) + NW'(s3_pc_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (en) begin
         s4_v_ff <= s3_v_ff;
      end
      if (en) begin
         for (int k = 0; k < LANES; k++) begin
            s4_neg_ff[k] <= s4_n[k][NW-1];
            s4_mag_ff[k] <= s4_n[k][NW-1] ? $unsigned(-s4_n[k]) : $unsigned(s4_n[k]);
         end
         s4_den_ff   <= s3_den_ff;
         s4_degen_ff <= s3_degen_ff;
      end
   end

   // ---- divider: entry 0 holds overflow check, then one quotient bit a stage ----
   logic                dv_v_ff     [QBITS+1];
   logic                dv_degen_ff [QBITS+1];
   logic [DENW-1:0]     dv_den_ff   [QBITS+1];
   logic [LANES-1:0]    dv_neg_ff   [QBITS+1];
   logic [LANES-1:0]    dv_big_ff   [QBITS+1];
   logic [REMW-1:0]     dv_rem_ff   [QBITS+1][LANES];
   logic [VW-1:0]       dv_low_ff   [QBITS+1][LANES];
   logic [QBITS-1:0]    dv_q_ff     [QBITS+1][LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (en) begin
         dv_v_ff[0] <= s4_v_ff;
      end
      if (en) begin
         for (int k = 0; k < LANES; k++) begin
            // quotient of 2^32 or more saturates regardless of the low bits
            dv_big_ff[0][k] <= (s4_mag_ff[k] >= (NW'(s4_den_ff) << VW));
            dv_rem_ff[0][k] <= REMW'(s4_mag_ff[k][2*VW-1:VW]);
            dv_low_ff[0][k] <= s4_mag_ff[k][VW-1:0];
            dv_q_ff[0][k]   <= '0;
         end
         dv_neg_ff[0]   <= s4_neg_ff;
         dv_den_ff[0]   <= s4_den_ff;
         dv_degen_ff[0] <= s4_degen_ff;
      end
   end

   for (genvar s = 0; s < QBITS; s++) begin : g_div
      logic [REMW:0] trial [LANES];
      logic [LANES-1:0] fits;
      always_comb begin
         for (int k = 0; k < LANES; k++) begin
            trial[k] = {dv_rem_ff[s][k], dv_low_ff[s][k][VW-1]};
            fits[k]  = (trial[k] >= {1'b0, dv_den_ff[s]});
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[s+1] <= 1'b0;
         end else if (en) begin
            dv_v_ff[s+1] <= dv_v_ff[s];
         end
         if (en) begin
            for (int k = 0; k < LANES; k++) begin
               dv_rem_ff[s+1][k] <= fits[k] ? REMW'(trial[k] - {1'b0, dv_den_ff[s]})
                                            : REMW'(trial[k]);
               dv_low_ff[s+1][k] <= {dv_low_ff[s][k][VW-2:0], 1'b0};
               dv_q_ff[s+1][k]   <= {dv_q_ff[s][k][QBITS-2:0], fits[k]};
            end
            dv_big_ff[s+1]   <= dv_big_ff[s];
            dv_neg_ff[s+1]   <= dv_neg_ff[s];
            dv_den_ff[s+1]   <= dv_den_ff[s];
            dv_degen_ff[s+1] <= dv_degen_ff[s];
         end
      end
   end

   // ---- rounding (half away from zero) and saturation ----
   logic [VW-1:0]    fin_val [LANES];
   logic [LANES-1:0] fin_sat;
   logic [VW:0]      fin_qm  [LANES];
   logic [95:0]      fin_data;
   rsp_flags_type    fin_user;

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         fin_qm[k] = {1'b0, dv_q_ff[QBITS][k]}
                   + (VW+1)'({dv_rem_ff[QBITS][k], 1'b0} >= {1'b0, dv_den_ff[QBITS]});
         if (!dv_neg_ff[QBITS][k]) begin
            fin_sat[k] = dv_big_ff[QBITS][k] || (fin_qm[k] > {1'b0, POS_MAX});
            fin_val[k] = fin_sat[k] ? POS_MAX : fin_qm[k][VW-1:0];
         end else begin
            fin_sat[k] = dv_big_ff[QBITS][k] || (fin_qm[k] > {1'b0, NEG_MIN});
            fin_val[k] = fin_sat[k] ? NEG_MIN : VW'(-fin_qm[k]);
         end
         if (dv_degen_ff[QBITS]) begin
            fin_val[k] = '0;
            fin_sat[k] = 1'b0;
         end
      end
      fin_data = {fin_val[2], fin_val[1], fin_val[0]};
      fin_user.degenerate = dv_degen_ff[QBITS];
      fin_user.saturated  = |fin_sat;
   end

   // ---- output register and skid ----
   logic          out_v_ff;
   logic [95:0]   out_data_ff;
   rsp_flags_type out_user_ff;
   logic [95:0]   skid_data_ff;
   rsp_flags_type skid_user_ff;
   logic          pop;
   logic          arrive;

   assign pop    = out_v_ff & rsp_tready;
   assign arrive = en & dv_v_ff[QBITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (pop) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end
      end else if (!out_v_ff || pop) begin
         out_v_ff <= arrive;
      end else if (arrive) begin
         skid_v_ff <= 1'b1;
      end
      if (skid_v_ff) begin
         if (pop) begin
            out_data_ff <= skid_data_ff;
            out_user_ff <= skid_user_ff;
         end
      end else if (!out_v_ff || pop) begin
         out_data_ff <= fin_data;
         out_user_ff <= fin_user;
      end else begin
         skid_data_ff <= fin_data;
         skid_user_ff <= fin_user;
      end
   end

   assign req_tready = en;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

endmodule
`default_nettype wire

/* src/qvr_checker.sv */
// Port-level checks on the quaternion vector rotator, bound to the top level.
`default_nettype none
module qvr_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [95:0]  rsp_tdata,
   input wire qvr_pkg::rsp_flags_type rsp_tuser
);
   import qvr_pkg::*;

   // a zero quaternion gives a zero vector and no clipping
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser.degenerate |-> rsp_tdata == '0 && !rsp_tuser.saturated)
      else $error("degenerate result not zero");

   // clipping leaves at least one component at a range limit
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser.saturated |->
         rsp_tdata[31:0] == POS_MAX || rsp_tdata[31:0] == NEG_MIN ||
         rsp_tdata[63:32] == POS_MAX || rsp_tdata[63:32] == NEG_MIN ||
         rsp_tdata[95:64] == POS_MAX || rsp_tdata[95:64] == NEG_MIN)
      else $error("saturated flag without a clipped component");

   // nothing emerges straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a result holds until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped under stall");

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
